>>> rtl/pf_pkg.sv
// Package: shared constants and square geometry helpers for the Playfair pair decryptor.
`timescale 1ns / 1ps

package pf_pkg;

  // Item kinds carried in s_tuser
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_PAIR   = 2'd2;

  // Alphabet and square size
  localparam int unsigned SIDE    = 5;
  localparam int unsigned CELLS   = 25;
  localparam int unsigned LETTERS = 26;

  localparam logic [4:0] LETTER_I  = 5'd8;
  localparam logic [4:0] LETTER_J  = 5'd9;
  localparam logic [4:0] LAST_CODE = 5'd25;
  localparam logic [4:0] CELL_CNT  = 5'd25;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;

  // J shares the cell of I
  function automatic letter_t fold_j(input letter_t l);
    return (l == LETTER_J) ? LETTER_I : l;
  endfunction

  // Row of a cell index 0..24 (division by five as a compare chain)
  function automatic coord_t row_of(input cell_t c);
    coord_t r;
    if (c >= 5'd20)      r = 3'd4;
    else if (c >= 5'd15) r = 3'd3;
    else if (c >= 5'd10) r = 3'd2;
    else if (c >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  // Column of a cell index 0..24
  function automatic coord_t col_of(input cell_t c);
    cell_t base;
    coord_t r;
    r    = row_of(c);
    base = ({2'b00, r} << 2) + {2'b00, r};
    return coord_t'(c - base);
  endfunction

  // Cell index from row and column
  function automatic cell_t cell_at(input coord_t r, input coord_t k);
    return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, k};
  endfunction

  // Step one place back with wraparound
  function automatic coord_t step_back(input coord_t v);
    return (v == 3'd0) ? 3'd4 : v - 3'd1;
  endfunction

endpackage

>>> rtl/pf_locate.sv
// Playfair decryption rule: maps the two cipher cells to the two plaintext cells.
`timescale 1ns / 1ps

module pf_locate (
  input  logic [4:0] cell_a,
  input  logic [4:0] cell_b,
  output logic [4:0] plain_cell_a,
  output logic [4:0] plain_cell_b
);

  logic [2:0] row_a;
  logic [2:0] col_a;
  logic [2:0] row_b;
  logic [2:0] col_b;

  // split cells into coordinates
  always_comb begin
    row_a = pf_pkg::row_of(cell_a);
    col_a = pf_pkg::col_of(cell_a);
    row_b = pf_pkg::row_of(cell_b);
    col_b = pf_pkg::col_of(cell_b);
  end

  // same row: left; same column: up; else rectangle corners
  always_comb begin
    if (row_a == row_b) begin
      plain_cell_a = pf_pkg::cell_at(row_a, pf_pkg::step_back(col_a));
      plain_cell_b = pf_pkg::cell_at(row_b, pf_pkg::step_back(col_b));
    end else if (col_a == col_b) begin
      plain_cell_a = pf_pkg::cell_at(pf_pkg::step_back(row_a), col_a);
      plain_cell_b = pf_pkg::cell_at(pf_pkg::step_back(row_b), col_b);
    end else begin
      plain_cell_a = pf_pkg::cell_at(row_a, col_b);
      plain_cell_b = pf_pkg::cell_at(row_b, col_a);
    end
  end

endmodule

>>> rtl/playfair_pair_decryptor.sv
// Top level: Playfair square builder and pair decryptor around two square memories.
// Key letter: placed on accept; next item accepted in the following cycle.
// Finish: the fill walks all 26 letter codes, one per cycle; next item accepted after the walk.
// Pair: letter-to-cell read, then cell-to-letter read, then output register; next item accepted
//   once the result is registered, later if stalled; an unfinished square gives an error result.
// Reset clears placed mask, fill count, ready flag and control; the two square memories
//   are not cleared and hold nothing meaningful until written.
`timescale 1ns / 1ps

module playfair_pair_decryptor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [4:0] first_letter, [9:5] second_letter, [15:10] zero
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [4:0] plain_a, [9:5] plain_b, [15:10] zero
  output logic [0:0]  m_tuser    // [0] not_ready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_LOOK = 2'd2;
  localparam logic [1:0] ST_READ = 2'd3;

  logic [1:0]  state;
  logic [25:0] placed_mask;
  logic [4:0]  fill_count;
  logic        square_ready;
  logic [4:0]  fill_letter;
  logic        err;
  logic        bad_a;
  logic        bad_b;

  // square memories
  logic [4:0] cell_letter [0:24];
  logic [4:0] letter_cell [0:25];
  logic [4:0] lc_rd_a;
  logic [4:0] lc_rd_b;
  logic [4:0] cl_rd_a;
  logic [4:0] cl_rd_b;

  logic       accept;
  logic [4:0] in_a;
  logic [4:0] in_b;
  logic [4:0] key_letter;
  logic       key_wr;
  logic       fill_wr;
  logic       wr_en;
  logic [4:0] wr_letter;
  logic       lc_rd_en;
  logic [4:0] lc_addr_a;
  logic [4:0] lc_addr_b;
  logic [4:0] cell_a;
  logic [4:0] cell_b;
  logic [4:0] plain_cell_a;
  logic [4:0] plain_cell_b;
  logic       out_free;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE) && !rst;
  assign in_a     = s_tdata[4:0];
  assign in_b     = s_tdata[9:5];
  assign out_free = !m_tvalid || m_tready;

  // placement of a key letter or of the next letter in the fill walk
  assign key_letter = pf_pkg::fold_j(in_a);
  assign key_wr = accept && (s_tuser == pf_pkg::KIND_KEY) && !square_ready &&
                  (in_a <= pf_pkg::LAST_CODE) && !placed_mask[key_letter] &&
                  (fill_count < pf_pkg::CELL_CNT);
  assign fill_wr = (state == ST_FILL) && (fill_letter != pf_pkg::LETTER_J) &&
                   !placed_mask[fill_letter] && (fill_count < pf_pkg::CELL_CNT);
  assign wr_en     = key_wr || fill_wr;
  assign wr_letter = (state == ST_FILL) ? fill_letter : key_letter;

  // pair lookup addresses; out-of-range codes sit in cell 0
  assign lc_rd_en  = accept && (s_tuser == pf_pkg::KIND_PAIR) && square_ready;
  assign lc_addr_a = (in_a > pf_pkg::LAST_CODE) ? 5'd0 : pf_pkg::fold_j(in_a);
  assign lc_addr_b = (in_b > pf_pkg::LAST_CODE) ? 5'd0 : pf_pkg::fold_j(in_b);

  // memory writes, letter-to-cell reads and cell-to-letter reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_letter[fill_count] <= wr_letter;
      letter_cell[wr_letter]  <= fill_count;
    end
    if (lc_rd_en) begin
      lc_rd_a <= letter_cell[lc_addr_a];
      lc_rd_b <= letter_cell[lc_addr_b];
      bad_a   <= (in_a > pf_pkg::LAST_CODE);
      bad_b   <= (in_b > pf_pkg::LAST_CODE);
    end
    if (state == ST_LOOK) begin
      cl_rd_a <= cell_letter[plain_cell_a];
      cl_rd_b <= cell_letter[plain_cell_b];
    end
  end

  assign cell_a = bad_a ? 5'd0 : lc_rd_a;
  assign cell_b = bad_b ? 5'd0 : lc_rd_b;

  pf_locate u_locate (
    .cell_a       (cell_a),
    .cell_b       (cell_b),
    .plain_cell_a (plain_cell_a),
    .plain_cell_b (plain_cell_b)
  );

  // control sequencer and square status
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      placed_mask  <= '0;
      fill_count   <= '0;
      square_ready <= 1'b0;
      fill_letter  <= '0;
      err          <= 1'b0;
    end else begin
      if (wr_en) begin
        placed_mask[wr_letter] <= 1'b1;
        fill_count             <= fill_count + 5'd1;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (s_tuser)
              pf_pkg::KIND_FINISH: begin
                if (!square_ready) begin
                  fill_letter <= '0;
                  state       <= ST_FILL;
                end
              end
              pf_pkg::KIND_PAIR: begin
                err   <= !square_ready;
                state <= square_ready ? ST_LOOK : ST_READ;
              end
              default: ;
            endcase
          end
        end
        ST_FILL: begin
          if (fill_letter == pf_pkg::LAST_CODE) begin
            square_ready <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            fill_letter <= fill_letter + 5'd1;
          end
        end
        ST_LOOK: begin
          state <= ST_READ;
        end
        ST_READ: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_READ && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ && out_free) begin
      m_tdata <= err ? 16'd0 : {6'd0, cl_rd_b, cl_rd_a};
      m_tuser <= err;
    end
  end

  // checks
  a_ready_sticks: assert property (@(posedge clk) disable iff (rst)
    square_ready |=> square_ready) else $error("square ready flag dropped");

  a_full_when_ready: assert property (@(posedge clk) disable iff (rst)
    square_ready |-> fill_count == pf_pkg::CELL_CNT) else $error("ready square not full");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= pf_pkg::CELL_CNT) else $error("fill count beyond square");

  a_fill_not_ready: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL |-> !square_ready) else $error("fill walk on a finished square");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tdata == 16'd0) else $error("error result carries letters");

endmodule
